FILE: rtl/tle_pkg.sv
// Shared types, constants and codes for the telnet line editor.
package tle_pkg;

   localparam int LINE_DEPTH = 64;
   localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int LEN_W      = $clog2(LINE_DEPTH + 1);

   localparam logic [7:0] B_IAC  = 8'd255;
   localparam logic [7:0] B_DONT = 8'd254;
   localparam logic [7:0] B_WILL = 8'd251;
   localparam logic [7:0] B_SB   = 8'd250;
   localparam logic [7:0] B_SE   = 8'd240;
   localparam logic [7:0] B_DEL  = 8'd127;
   localparam logic [7:0] B_SPC  = 8'd32;
   localparam logic [7:0] B_BS   = 8'd8;
   localparam logic [7:0] B_CR   = 8'd13;
   localparam logic [7:0] B_LF   = 8'd10;

   localparam logic [1:0] KIND_ECHO  = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   typedef logic [2:0] act_type;
   localparam act_type ACT_DROP        = 3'd0;
   localparam act_type ACT_EOL_EMPTY   = 3'd1;
   localparam act_type ACT_EOL_LINE    = 3'd2;
   localparam act_type ACT_ERASE       = 3'd3;
   localparam act_type ACT_STORE_ECHO  = 3'd4;
   localparam act_type ACT_STORE_QUIET = 3'd5;

   typedef logic [2:0] sel_type;
   localparam sel_type SEL_BYTE  = 3'd0;
   localparam sel_type SEL_BS    = 3'd1;
   localparam sel_type SEL_SPC   = 3'd2;
   localparam sel_type SEL_EMPTY = 3'd3;
   localparam sel_type SEL_LINE  = 3'd4;

   typedef struct packed {
      logic    accept;
      logic    phase_wr;
      logic    store;
      logic    len_dec;
      logic    len_clr;
      logic    idx_clr;
      logic    idx_inc;
      logic    out_load;
      sel_type out_sel;
      logic    out_last;
   } cmd_type;

   typedef struct packed {
      act_type act;
      logic    out_free;
      logic    idx_last;
   } sts_type;

endpackage

FILE: rtl/tle_dpath.sv
// Datapath: Telnet filter phase, line store, length, read index and result register.
module tle_dpath import tle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_rx_byte,
   input  cmd_type    cmd,
   output sts_type    sts,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic       rsp_last
);

   localparam logic [2:0] PH_NORMAL  = 3'd0;
   localparam logic [2:0] PH_IAC     = 3'd1;
   localparam logic [2:0] PH_OPTION  = 3'd2;
   localparam logic [2:0] PH_SUB     = 3'd3;
   localparam logic [2:0] PH_SUB_IAC = 3'd4;

   logic [7:0]       byte_ff;
   logic [2:0]       phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [6:0]       mem [LINE_DEPTH];
   logic [6:0]       rd_data_ff;
   logic             valid_ff, valid_in;
   logic [1:0]       kind_ff, kind_in;
   logic [7:0]       data_ff, data_in;
   logic             last_ff, last_in;
   logic             is_normal;
   act_type          act;

   always_comb begin
      phase_in = PH_NORMAL;
      unique case (phase_ff)
         PH_IAC: begin
            if (byte_ff >= B_WILL && byte_ff <= B_DONT) phase_in = PH_OPTION;
            else if (byte_ff == B_SB)                   phase_in = PH_SUB;
            else                                        phase_in = PH_NORMAL;
         end
         PH_OPTION:  phase_in = PH_NORMAL;
         PH_SUB:     phase_in = (byte_ff == B_IAC) ? PH_SUB_IAC : PH_SUB;
         PH_SUB_IAC: phase_in = (byte_ff == B_SE) ? PH_NORMAL : PH_SUB;
         default:    phase_in = (byte_ff == B_IAC) ? PH_IAC : PH_NORMAL;
      endcase
   end

   assign is_normal = !(phase_ff == PH_IAC || phase_ff == PH_OPTION ||
                        phase_ff == PH_SUB || phase_ff == PH_SUB_IAC);

   always_comb begin
      act = ACT_DROP;
      if (!is_normal || byte_ff == 8'd0 || byte_ff[7]) begin
         act = ACT_DROP;
      end else if (byte_ff == B_CR || byte_ff == B_LF) begin
         act = (len_ff == '0) ? ACT_EOL_EMPTY : ACT_EOL_LINE;
      end else if (byte_ff == B_BS || byte_ff == B_DEL) begin
         act = (len_ff == '0) ? ACT_DROP : ACT_ERASE;
      end else if (len_ff >= LEN_W'(LINE_DEPTH)) begin
         act = ACT_DROP;
      end else begin
         act = (byte_ff >= B_SPC) ? ACT_STORE_ECHO : ACT_STORE_QUIET;
      end
   end

   always_comb begin
      len_in = len_ff;
      if (cmd.len_clr)      len_in = '0;
      else if (cmd.store)   len_in = len_ff + LEN_W'(1);
      else if (cmd.len_dec) len_in = len_ff - LEN_W'(1);
      idx_in = idx_ff;
      if (cmd.idx_clr)      idx_in = '0;
      else if (cmd.idx_inc) idx_in = idx_ff + IDX_W'(1);
   end

   always_comb begin
      kind_in = KIND_ECHO;
      data_in = byte_ff;
      unique case (cmd.out_sel)
         SEL_BYTE:  begin kind_in = KIND_ECHO;  data_in = byte_ff;            end
         SEL_BS:    begin kind_in = KIND_ECHO;  data_in = B_BS;               end
         SEL_SPC:   begin kind_in = KIND_ECHO;  data_in = B_SPC;              end
         SEL_EMPTY: begin kind_in = KIND_EMPTY; data_in = 8'd0;               end
         SEL_LINE:  begin kind_in = KIND_LINE;  data_in = {1'b0, rd_data_ff}; end
         default:   begin kind_in = KIND_ECHO;  data_in = byte_ff;            end
      endcase
      last_in  = cmd.out_last;
      valid_in = cmd.out_load ? 1'b1 : (rsp_stall ? valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
         len_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.phase_wr) phase_ff <= phase_in;
         len_ff   <= len_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) byte_ff <= req_rx_byte;
      idx_ff <= idx_in;
      if (cmd.out_load) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) mem[len_ff[IDX_W-1:0]] <= byte_ff[6:0];
      rd_data_ff <= mem[idx_ff];
   end

   assign sts.act      = act;
   assign sts.out_free = !valid_ff || !rsp_stall;
   assign sts.idx_last = ({1'b0, idx_ff} + LEN_W'(1)) == len_ff;

   assign rsp_valid = valid_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_data  = data_ff;
   assign rsp_last  = last_ff;

endmodule

FILE: rtl/tle_ctrl.sv
// Controller: sequences byte intake, decode, echo and line readout.
module tle_ctrl import tle_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SINGLE = 3'd2;
   localparam logic [2:0] S_ERASE  = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_LINE   = 3'd5;

   logic [2:0] state_ff, state_in;
   act_type    act_ff, act_in;
   logic [1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.out_sel = SEL_BYTE;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            cmd.phase_wr = 1'b1;
            act_in       = sts.act;
            step_in      = '0;
            unique case (sts.act) inside
               ACT_EOL_EMPTY, ACT_STORE_ECHO: begin
                  cmd.store = (sts.act == ACT_STORE_ECHO);
                  state_in  = S_SINGLE;
               end
               ACT_STORE_QUIET: begin
                  cmd.store = 1'b1;
                  state_in  = S_IDLE;
               end
               ACT_ERASE: begin
                  cmd.len_dec = 1'b1;
                  state_in    = S_ERASE;
               end
               ACT_EOL_LINE: begin
                  cmd.idx_clr = 1'b1;
                  state_in    = S_READ;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SINGLE: begin
            cmd.out_sel  = (act_ff == ACT_EOL_EMPTY) ? SEL_EMPTY : SEL_BYTE;
            cmd.out_last = 1'b1;
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_ERASE: begin
            cmd.out_sel  = (step_ff == 2'd1) ? SEL_SPC : SEL_BS;
            cmd.out_last = (step_ff == 2'd2);
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               step_in      = step_ff + 2'd1;
               if (step_ff == 2'd2) state_in = S_IDLE;
            end
         end
         S_READ: state_in = S_LINE;
         S_LINE: begin
            cmd.out_sel  = SEL_LINE;
            cmd.out_last = sts.idx_last;
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (sts.idx_last) begin
                  cmd.len_clr = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      step_ff <= step_in;
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

FILE: rtl/telnet_line_editor.sv
// Top level of the telnet line editor: Telnet filter and line editing.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_rx_byte
//   rsp      out  rsp_valid/rsp_stall  rsp_kind, rsp_data, rsp_last
//
// A byte is taken in S_IDLE and decoded in S_DECODE; an echo or empty-line
// result follows in S_SINGLE, an erase gives three results (BS, space, BS).
// Line completion reads the line store an entry at a time (S_READ, S_LINE).
// Result register decouples rsp_stall; output waits while full and stalled.
// Synchronous reset clears the filter phase and line length; no clear pass.
module telnet_line_editor import tle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic       rsp_last
);

   cmd_type cmd;
   sts_type sts;

   tle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tle_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_rx_byte (req_rx_byte),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_kind    (rsp_kind),
      .rsp_data    (rsp_data),
      .rsp_last    (rsp_last)
   );

endmodule
